// ===== sv/jdm_pkg.sv =====
// shared types, constants and helpers of the joystick drive mixer
// no dependencies; imported by jdm_mac and joystick_drive_mixer
package jdm_pkg;

  localparam int unsigned MAC_A_W   = 48;
  localparam int unsigned MAC_B_W   = 16;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned INIT_W    = 32;

  localparam int unsigned STICK_W   = 8;
  localparam int unsigned DRIVE_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 9;

  // register indexes of the write port
  localparam logic [CFG_IDX_W-1:0] REG_FWD_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_ITEMS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_GAIN = 3'd5;

  // quartic coefficients, q32
  localparam logic [12:0] COEF_A = 13'd4218;
  localparam logic [18:0] COEF_B = 19'd300046;
  localparam logic [24:0] COEF_C = 25'd28995324;
  localparam logic [27:0] COEF_D = 28'd166601781;

  // stick percent: round(mag*6553600/127) = mag * 51603 + (19 * mag + 63) / 127
  localparam logic [15:0] MAG_SCALE = 16'd51603;
  // ceil(2^36 / 100), exact for dividends below 2^30
  localparam logic [29:0] RECIP_100 = 30'd687194768;
  localparam logic [15:0] MV_SCALE  = 16'd120;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P,
    ST_P2L,
    ST_P2H,
    ST_P3L,
    ST_P3H,
    ST_P4L,
    ST_P4H,
    ST_A,
    ST_CL,
    ST_CH,
    ST_DL,
    ST_DH,
    ST_BL,
    ST_BH,
    ST_Y,
    ST_GL,
    ST_GH,
    ST_TG,
    ST_TB1,
    ST_TB2,
    ST_TW,
    ST_OL,
    ST_OR
  } jdm_state_e;

  // one step of the shared multiply-accumulate unit
  typedef struct packed {
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic               hi;    // product shifted up by one b chunk
    logic               sub;   // subtract the product
    logic               load;  // start from init instead of the accumulator
    logic [INIT_W-1:0]  init;
  } mac_req_t;

  // (19 * mag + 63) / 127 by reciprocal, exact for mag up to 127
  function automatic logic [4:0] mag_frac(input logic [6:0] mag);
    logic [11:0] y;
    logic [25:0] prod;
    y    = 12'(mag) * 12'd19 + 12'd63;
    prod = 26'(y) * 26'd8257;
    return prod[24:20];
  endfunction

endpackage

// ===== sv/joystick_drive_mixer.sv =====
// joystick drive mixer: one joystick sample in, left and right drive commands out
// depends on jdm_pkg and jdm_mac
//
// One request takes one sample and gives one pair of drive values in millivolts.
// A single 48x16 multiply-accumulate unit does all the arithmetic under a step
// sequencer, so the sample rate is set by how many steps that unit runs: 17 steps
// per nonzero axis for the quartic shaping, 1 to 4 steps for gain, smoothing and
// warm-up of the turn, and 2 steps for the millivolt conversion. A sample with
// both axes zero goes straight to the millivolt conversion. The input is ready
// only while the sequencer is idle; the result sits in an output register, and
// the sequencer stalls in its last step only while an earlier result is still
// not taken.
module joystick_drive_mixer
  import jdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // turn_stick, forward_stick
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata   // left_drive, right_drive
);

  jdm_state_e state_q, state_d;

  logic [6:0] fwd_off_q, trn_off_q;
  logic [8:0] trn_gain_q, rise_w_q, warm_g_q;
  logic [7:0] warm_n_q;

  logic [7:0]  turn_raw_q, fwd_raw_q;
  logic        axis_q;
  logic [22:0] p_q;
  logic [29:0] p2_q;
  logic [35:0] p3_q;
  logic [42:0] p4_q;
  logic [23:0] f_q;
  logic [30:0] y_q;
  logic [22:0] fwd_q, v_q;
  logic [23:0] t_q, smooth_q;
  logic [24:0] m_q;
  logic        warm_q;
  logic [7:0]  run_q;
  logic [15:0] lft_q;
  logic [31:0] out_q;
  logic        out_valid_q;

  mac_req_t         mreq;
  logic [ACC_W-1:0] acc;
  logic             mac_en;

  logic        in_acc, out_free, stall;
  logic [7:0]  raw_sel, raw_neg;
  logic [6:0]  mag, off_c, off_sel;
  logic [8:0]  w_c, w_inv;
  logic [23:0] f_d;
  logic [22:0] shaped;
  logic [23:0] t_d;
  logic        warm_d;
  logic [26:0] fs, ts, l_s, r_s;
  logic [25:0] mag_l, mag_r;
  logic [16:0] mv;
  logic [15:0] drv;

  function automatic logic [15:0] sat_mv(input logic [16:0] v, input logic neg);
    logic [15:0] r;
    if (neg) begin
      r = (v > 17'd32768) ? 16'h8000 : (16'd0 - v[15:0]);
    end else begin
      r = (v > 17'd32767) ? 16'h7fff : v[15:0];
    end
    return r;
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_off_q  <= 7'd6;
      trn_off_q  <= 7'd8;
      trn_gain_q <= 9'd205;
      rise_w_q   <= 9'd154;
      warm_n_q   <= 8'd5;
      warm_g_q   <= 9'd230;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FWD_OFFSET:   fwd_off_q  <= cfg_wdata_i[6:0];
        REG_TURN_OFFSET:  trn_off_q  <= cfg_wdata_i[6:0];
        REG_TURN_GAIN:    trn_gain_q <= cfg_wdata_i;
        REG_RISE_WEIGHT:  rise_w_q   <= cfg_wdata_i;
        REG_WARMUP_ITEMS: warm_n_q   <= cfg_wdata_i[7:0];
        REG_WARMUP_GAIN:  warm_g_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign stall         = (state_q == ST_OR) && !out_free;
  assign mac_en        = (state_q != ST_IDLE) && !stall;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // operand helpers
  always_comb begin
    raw_sel = axis_q ? turn_raw_q : fwd_raw_q;
    raw_neg = 8'd0 - raw_sel;
    if (!raw_sel[7]) begin
      mag = raw_sel[6:0];
    end else if (raw_sel == 8'h80) begin
      mag = 7'd127;
    end else begin
      mag = raw_neg[6:0];
    end
    off_sel = axis_q ? trn_off_q : fwd_off_q;
    off_c   = (off_sel > 7'd100) ? 7'd100 : off_sel;
    w_c     = (rise_w_q > 9'd256) ? 9'd256 : rise_w_q;
    w_inv   = 9'd256 - w_c;
    f_d     = acc[ACC_W-1] ? 24'd0 : acc[55:32];
    shaped  = acc[58:36] + {off_c, 16'd0};
    t_d     = acc[31:8];
    warm_d  = run_q < warm_n_q;

    fs    = fwd_raw_q[7] ? (27'd0 - 27'(fwd_q)) : 27'(fwd_q);
    ts    = turn_raw_q[7] ? (27'd0 - 27'(m_q)) : 27'(m_q);
    l_s   = fs + ts;
    r_s   = fs - ts;
    mag_l = l_s[26] ? 26'(27'd0 - l_s) : l_s[25:0];
    mag_r = r_s[26] ? 26'(27'd0 - r_s) : r_s[25:0];
    mv    = acc[32:16];
    drv   = sat_mv(mv, (state_q == ST_OL) ? l_s[26] : r_s[26]);
  end

  // step decoder for the shared unit
  always_comb begin
    mreq      = '0;
    mreq.load = 1'b1;
    unique case (state_q)
      ST_P: begin
        mreq.a    = MAC_A_W'(mag);
        mreq.b    = MAG_SCALE;
        mreq.init = INIT_W'(mag_frac(mag));
      end
      ST_P2L: begin
        mreq.a    = MAC_A_W'(p_q);
        mreq.b    = p_q[15:0];
        mreq.init = 32'd32768;
      end
      ST_P2H: begin
        mreq.a    = MAC_A_W'(p_q);
        mreq.b    = MAC_B_W'(p_q[22:16]);
        mreq.hi   = 1'b1;
        mreq.load = 1'b0;
      end
      ST_P3L: begin
        mreq.a    = MAC_A_W'(p2_q);
        mreq.b    = p_q[15:0];
        mreq.init = 32'd32768;
      end
      ST_P3H: begin
        mreq.a    = MAC_A_W'(p2_q);
        mreq.b    = MAC_B_W'(p_q[22:16]);
        mreq.hi   = 1'b1;
        mreq.load = 1'b0;
      end
      ST_P4L: begin
        mreq.a    = MAC_A_W'(p2_q);
        mreq.b    = p2_q[15:0];
        mreq.init = 32'd32768;
      end
      ST_P4H: begin
        mreq.a    = MAC_A_W'(p2_q);
        mreq.b    = MAC_B_W'(p2_q[29:16]);
        mreq.hi   = 1'b1;
        mreq.load = 1'b0;
      end
      ST_A: begin
        mreq.a    = MAC_A_W'(p4_q);
        mreq.b    = MAC_B_W'(COEF_A);
        mreq.init = 32'h8000_0000;
      end
      ST_CL: begin
        mreq.a    = MAC_A_W'(p2_q);
        mreq.b    = COEF_C[15:0];
        mreq.load = 1'b0;
      end
      ST_CH: begin
        mreq.a    = MAC_A_W'(p2_q);
        mreq.b    = MAC_B_W'(COEF_C[24:16]);
        mreq.hi   = 1'b1;
        mreq.load = 1'b0;
      end
      ST_DL: begin
        mreq.a    = MAC_A_W'(COEF_D);
        mreq.b    = p_q[15:0];
        mreq.load = 1'b0;
      end
      ST_DH: begin
        mreq.a    = MAC_A_W'(COEF_D);
        mreq.b    = MAC_B_W'(p_q[22:16]);
        mreq.hi   = 1'b1;
        mreq.load = 1'b0;
      end
      ST_BL: begin
        mreq.a    = MAC_A_W'(p3_q);
        mreq.b    = COEF_B[15:0];
        mreq.sub  = 1'b1;
        mreq.load = 1'b0;
      end
      ST_BH: begin
        mreq.a    = MAC_A_W'(p3_q);
        mreq.b    = MAC_B_W'(COEF_B[18:16]);
        mreq.hi   = 1'b1;
        mreq.sub  = 1'b1;
        mreq.load = 1'b0;
      end
      ST_Y: begin
        mreq.a    = MAC_A_W'(f_q);
        mreq.b    = MAC_B_W'(7'd100 - off_c);
        mreq.init = 32'd50;
      end
      ST_GL: begin
        mreq.a    = MAC_A_W'(y_q);
        mreq.b    = RECIP_100[15:0];
      end
      ST_GH: begin
        mreq.a    = MAC_A_W'(y_q);
        mreq.b    = MAC_B_W'(RECIP_100[29:16]);
        mreq.hi   = 1'b1;
        mreq.load = 1'b0;
      end
      ST_TG: begin
        mreq.a    = MAC_A_W'(v_q);
        mreq.b    = MAC_B_W'(trn_gain_q);
        mreq.init = 32'd128;
      end
      ST_TB1: begin
        mreq.a    = MAC_A_W'(t_q);
        mreq.b    = MAC_B_W'(w_c);
        mreq.init = 32'd128;
      end
      ST_TB2: begin
        mreq.a    = MAC_A_W'(smooth_q);
        mreq.b    = MAC_B_W'(w_inv);
        mreq.load = 1'b0;
      end
      ST_TW: begin
        mreq.a    = MAC_A_W'(smooth_q);
        mreq.b    = MAC_B_W'(warm_g_q);
        mreq.init = 32'd128;
      end
      ST_OL: begin
        mreq.a    = MAC_A_W'(mag_l);
        mreq.b    = MV_SCALE;
        mreq.init = 32'd32768;
      end
      ST_OR: begin
        mreq.a    = MAC_A_W'(mag_r);
        mreq.b    = MV_SCALE;
        mreq.init = 32'd32768;
      end
      default: ;
    endcase
  end

  jdm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mac_en),
    .req_i  (mreq),
    .sum_o  (acc)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tdata[15:8] == 8'd0 && s_axis_tdata[7:0] == 8'd0) begin
            state_d = ST_OL;
          end else begin
            state_d = ST_P;
          end
        end
      end
      ST_P:   state_d = ST_P2L;
      ST_P2L: state_d = ST_P2H;
      ST_P2H: state_d = ST_P3L;
      ST_P3L: state_d = ST_P3H;
      ST_P3H: state_d = ST_P4L;
      ST_P4L: state_d = ST_P4H;
      ST_P4H: state_d = ST_A;
      ST_A:   state_d = ST_CL;
      ST_CL:  state_d = ST_CH;
      ST_CH:  state_d = ST_DL;
      ST_DL:  state_d = ST_DH;
      ST_DH:  state_d = ST_BL;
      ST_BL:  state_d = ST_BH;
      ST_BH:  state_d = ST_Y;
      ST_Y:   state_d = ST_GL;
      ST_GL:  state_d = ST_GH;
      ST_GH: begin
        if (axis_q) begin
          state_d = ST_TG;
        end else if (turn_raw_q != 8'd0) begin
          state_d = ST_P;
        end else begin
          state_d = ST_OL;
        end
      end
      ST_TG: begin
        if (t_d > smooth_q) begin
          state_d = ST_TB1;
        end else begin
          state_d = warm_d ? ST_TW : ST_OL;
        end
      end
      ST_TB1: state_d = ST_TB2;
      ST_TB2: state_d = warm_q ? ST_TW : ST_OL;
      ST_TW:  state_d = ST_OL;
      ST_OL:  state_d = ST_OR;
      ST_OR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // turn state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q    <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && s_axis_tdata[7:0] == 8'd0 && s_axis_tdata[15:8] != 8'd0) begin
        run_q <= '0;
      end
      if (state_q == ST_TG) begin
        if (run_q != 8'hff) begin
          run_q <= run_q + 8'd1;
        end
        if (!(t_d > smooth_q)) begin
          smooth_q <= t_d;
        end
      end
      if (state_q == ST_TB2) begin
        smooth_q <= acc[31:8];
      end
      if (state_q == ST_OR && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      turn_raw_q <= s_axis_tdata[7:0];
      fwd_raw_q  <= s_axis_tdata[15:8];
      axis_q     <= (s_axis_tdata[15:8] == 8'd0);
      fwd_q      <= '0;
      m_q        <= '0;
    end
    unique case (state_q)
      ST_P:   p_q  <= acc[22:0];
      ST_P2H: p2_q <= acc[45:16];
      ST_P3H: p3_q <= acc[51:16];
      ST_P4H: p4_q <= acc[58:16];
      ST_BH:  f_q  <= f_d;
      ST_Y:   y_q  <= acc[30:0];
      ST_GH: begin
        if (axis_q) begin
          v_q <= shaped;
        end else begin
          fwd_q  <= shaped;
          axis_q <= 1'b1;
        end
      end
      ST_TG: begin
        t_q    <= t_d;
        warm_q <= warm_d;
        if (!(t_d > smooth_q) && !warm_d) begin
          m_q <= 25'(t_d);
        end
      end
      ST_TB2: begin
        if (!warm_q) begin
          m_q <= 25'(acc[31:8]);
        end
      end
      ST_TW: m_q   <= acc[32:8];
      ST_OL: lft_q <= drv;
      ST_OR: begin
        if (out_free) begin
          out_q <= {drv, lft_q};
        end
      end
      default: ;
    endcase
  end

  // run count only steps up by one or drops to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q != $past(run_q)) |-> (run_q == 8'd0 || run_q == $past(run_q) + 8'd1))
    else $error("turn run count jumped");

  // an all-zero sample leaves the turn state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata == 16'd0) |=> ($stable(smooth_q) && $stable(run_q)))
    else $error("zero sample changed turn state");

  // a result appears only from the final conversion step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OR))
    else $error("result raised outside final step");

endmodule

// ===== sv/jdm_mac.sv =====
// shared multiply-accumulate unit of the joystick drive mixer
// depends on jdm_pkg for the step request type
module jdm_mac
  import jdm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  mac_req_t         req_i,
  output logic [ACC_W-1:0] sum_o
);

  logic [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0] acc_d;
  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] base;

  always_comb begin
    prod  = ACC_W'(req_i.a) * ACC_W'(req_i.b);
    term  = req_i.hi ? (prod << MAC_B_W) : prod;
    base  = req_i.load ? ACC_W'(req_i.init) : acc_q;
    acc_d = req_i.sub ? (base - term) : (base + term);
  end

  assign sum_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== test/tb_joystick_drive_mixer.sv =====
// testbench of joystick_drive_mixer: directed and random joystick samples over several
// register settings, each drive pair checked against a bit-exact predictor
// depends on jdm_pkg and the joystick_drive_mixer rtl
`timescale 1ns / 1ps

module tb_joystick_drive_mixer
  import jdm_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [63:0] Q32_A = 64'd4218;
  localparam logic [63:0] Q32_B = 64'd300046;
  localparam logic [63:0] Q32_C = 64'd28995324;
  localparam logic [63:0] Q32_D = 64'd166601781;

  class drive_scoreboard;
    logic [6:0]  fwd_offset;
    logic [6:0]  turn_offset;
    logic [8:0]  turn_gain;
    logic [8:0]  rise_weight;
    logic [7:0]  warmup_items;
    logic [8:0]  warmup_gain;
    logic [23:0] smooth_turn;
    logic [7:0]  run_count;
    logic [31:0] drive_q[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      fwd_offset   = 7'd6;
      turn_offset  = 7'd8;
      turn_gain    = 9'd205;
      rise_weight  = 9'd154;
      warmup_items = 8'd5;
      warmup_gain  = 9'd230;
      smooth_turn  = '0;
      run_count    = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_FWD_OFFSET:   fwd_offset = val[6:0];
        REG_TURN_OFFSET:  turn_offset = val[6:0];
        REG_TURN_GAIN:    turn_gain = val;
        REG_RISE_WEIGHT:  rise_weight = val;
        REG_WARMUP_ITEMS: warmup_items = val[7:0];
        REG_WARMUP_GAIN:  warmup_gain = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function logic [6:0] stick_mag(logic [7:0] raw);
      logic [8:0] v;
      v = {1'b0, raw};
      if (raw[7]) begin
        v = 9'd256 - v;
        if (v > 9'd127) v = 9'd127;
      end
      return v[6:0];
    endfunction

    // shaped percent, q16
    function logic [31:0] shape(logic [6:0] mag, logic [6:0] off);
      logic [63:0] o, p, p2, p3, p4, pos, neg, acc, f;
      o   = (off > 7'd100) ? 64'd100 : 64'(off);
      p   = (64'(mag) * 64'd6553600 + 64'd63) / 64'd127;
      p2  = (p * p + 64'd32768) >> 16;
      p3  = (p2 * p + 64'd32768) >> 16;
      p4  = (p2 * p2 + 64'd32768) >> 16;
      pos = Q32_A * p4 + Q32_C * p2 + Q32_D * p;
      neg = Q32_B * p3;
      acc = (pos > neg) ? pos - neg : 64'd0;
      f   = (acc + 64'h8000_0000) >> 32;
      return 32'((f * (64'd100 - o) + 64'd50) / 64'd100 + (o << 16));
    endfunction

    function logic [15:0] to_millivolt(longint q);
      logic [63:0] mag, mv;
      mag = (q < 0) ? 64'(-q) : 64'(q);
      mv  = (mag * 64'd120 + 64'd32768) >> 16;
      if (q < 0) return (mv > 64'd32768) ? 16'h8000 : 16'(-mv);
      return (mv > 64'd32767) ? 16'h7FFF : mv[15:0];
    endfunction

    function void note_request(logic [7:0] turn, logic [7:0] fwd);
      longint fwd_q, turn_q;
      logic [63:0] v, t, w, m;
      fwd_q  = 0;
      turn_q = 0;
      if (turn == 8'd0 && fwd == 8'd0) begin
        drive_q.push_back(32'd0);
        return;
      end
      if (fwd != 8'd0) begin
        fwd_q = longint'(shape(stick_mag(fwd), fwd_offset));
        if (fwd[7]) fwd_q = -fwd_q;
      end
      if (turn != 8'd0) begin
        v = 64'(shape(stick_mag(turn), turn_offset));
        t = (v * 64'(turn_gain) + 64'd128) >> 8;
        w = (rise_weight > 9'd256) ? 64'd256 : 64'(rise_weight);
        if (t > 64'(smooth_turn))
          t = (t * w + 64'(smooth_turn) * (64'd256 - w) + 64'd128) >> 8;
        smooth_turn = t[23:0];
        m = 64'(smooth_turn);
        if (run_count < warmup_items) m = (m * 64'(warmup_gain) + 64'd128) >> 8;
        if (run_count != 8'hFF) run_count++;
        turn_q = longint'(m);
        if (turn[7]) turn_q = -turn_q;
      end else begin
        run_count = '0;
      end
      drive_q.push_back({to_millivolt(fwd_q - turn_q), to_millivolt(fwd_q + turn_q)});
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task check_result(logic [31:0] data);
      logic [31:0] want;
      results_seen++;
      if (drive_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", data));
        return;
      end
      want = drive_q.pop_front();
      if (data[15:0] !== want[15:0])
        report_mismatch($sformatf("left_drive %0d, predicted %0d",
                                  $signed(data[15:0]), $signed(want[15:0])));
      if (data[31:16] !== want[31:16])
        report_mismatch($sformatf("right_drive %0d, predicted %0d",
                                  $signed(data[31:16]), $signed(want[31:16])));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;

  int unsigned tx_idle_pct = 10;
  int unsigned rx_stall_pct = 10;

  drive_scoreboard sb;

  joystick_drive_mixer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic [7:0] turn, input logic [7:0] fwd);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fwd, turn};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(turn, fwd);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [6:0] fwd_off, input logic [6:0] turn_off,
                           input logic [8:0] gain, input logic [8:0] rise,
                           input logic [7:0] warm_n, input logic [8:0] warm_gain);
    write_reg(REG_FWD_OFFSET, 9'(fwd_off));
    write_reg(REG_TURN_OFFSET, 9'(turn_off));
    write_reg(REG_TURN_GAIN, gain);
    write_reg(REG_RISE_WEIGHT, rise);
    write_reg(REG_WARMUP_ITEMS, 9'(warm_n));
    write_reg(REG_WARMUP_GAIN, warm_gain);
  endtask

  function automatic logic [7:0] pick_stick(int unsigned zero_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 8'h00;
    if (r < zero_pct + 8) begin
      case ($urandom_range(0, 4))
        0: return 8'h7F;
        1: return 8'h80;
        2: return 8'h81;
        3: return 8'h01;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic run_random(int unsigned count, int unsigned turn_zero_pct,
                            int unsigned fwd_zero_pct);
    for (int unsigned i = 0; i < count; i++)
      send_sample(pick_stick(turn_zero_pct), pick_stick(fwd_zero_pct));
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, directed samples
    send_sample(8'h00, 8'h00);
    send_sample(8'h7F, 8'h00);
    send_sample(8'h00, 8'h7F);
    send_sample(8'h80, 8'h80);
    send_sample(8'h81, 8'h7F);
    send_sample(8'h01, 8'h01);
    send_sample(8'hFF, 8'hFF);
    send_sample(8'h7F, 8'h7F);
    send_sample(8'h14, 8'h40);
    send_sample(8'h7F, 8'hC0);
    send_sample(8'h00, 8'h32);
    send_sample(8'h00, 8'h00);
    for (int i = 0; i < 7; i++) send_sample(8'h60, 8'h20);
    send_sample(8'h00, 8'h80);
    send_sample(8'h40, 8'hC0);
    send_sample(8'h80, 8'h00);
    send_sample(8'hC0, 8'h00);
    drain();

    // extremes, one long stretch without idling and a long turning run
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_all(7'd100, 7'd100, 9'd256, 9'd256, 8'd255, 9'd256);
    run_random(300, 0, 15);
    drain();
    tx_idle_pct  = 10;
    rx_stall_pct = 10;

    write_all(7'd0, 7'd0, 9'd0, 9'd0, 8'd0, 9'd0);
    run_random(75, 15, 15);
    drain();
    run_random(75, 30, 15);
    drain();

    // values above the documented range
    write_all(7'd127, 7'd101, 9'd511, 9'd511, 8'd3, 9'd511);
    write_reg(REG_SPARE_6, 9'($urandom));
    write_reg(REG_SPARE_7, 9'($urandom));
    run_random(200, 10, 10);
    drain();

    for (int k = 0; k < 4; k++) begin
      write_all(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      run_random(90, 5 + 10 * k, 12);
      drain();
    end

    write_all(7'd6, 7'd8, 9'd205, 9'd154, 8'd5, 9'd230);
    run_random(100, 12, 12);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[joystick_drive_mixer] OK");
    end else begin
      $display("[joystick_drive_mixer] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[joystick_drive_mixer] ERROR");
    $finish;
  end

endmodule
